@@ src/bffa_pkg.sv @@
`timescale 1ns / 1ps
package bffa_pkg;

	localparam int PAGE_SHIFT = 12;                    // 4096-byte pages
	localparam int REQ_W      = 32;
	localparam int TOTAL_W    = REQ_W + 1;             // request plus header, no wrap
	localparam int NFULL_W    = TOTAL_W - PAGE_SHIFT;  // page count before range check
	localparam int PAGE_W     = 11;                    // holds any page index up to 255*8
	localparam int WADDR_W    = 8;                     // word address carried between modules
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 56;

	typedef enum logic [7:0] {
		REG_HEAP_BASE    = 8'd0,
		REG_HEADER_BYTES = 8'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_SCAN,
		ST_MARK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic               rd_en;
		logic [WADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [WADDR_W-1:0] wr_addr;
		logic [7:0]         wr_data;
	} mem_req_t;

	typedef struct packed {
		logic              ok;
		logic [PAGE_W-1:0] start;
		logic [8:0]        pages_taken;
	} res_t;

endpackage

@@ src/bitmap_first_fit_page_allocator_unit.sv @@
`timescale 1ns / 1ps
// First-fit page allocator over a page bitmap held in a one-port-read,
// one-port-write synchronous memory of BITMAP_BYTES words.
// Slave stream: tdata carries a request byte count. Master stream: tdata
// carries ok, address, start_page and pages_taken of the allocation.
// Configuration channel: cfg_index 0 writes the heap base, 1 the header size;
// other indexes are dropped. Write only while no request is in flight.
// One request is worked at a time. A request is first sized, then the bitmap
// is scanned word by word (up to BITMAP_BYTES words) for a free run, then
// each word the run spans is marked, and then the result is loaded. A request
// of zero pages or of more pages than the bitmap holds skips scan and mark.
// The next request is taken as soon as the result is in the output register,
// even while the receiver still holds it off.
// A stalled receiver holds the result; the sequencer waits for the register
// to free up before presenting the following result.
// Reset clears the configuration to base 0, header 4, and marks every page
// free at once through per-word valid bits; no clearing pass is needed.
module bitmap_first_fit_page_allocator_unit import bffa_pkg::*; #(
	parameter int BITMAP_BYTES = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [31:0] request_bytes
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] ok, [32:1] address, [40:33] start_page, [49:41] pages_taken, [55:50] zero
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	logic [31:0] heap_base_q;
	logic [7:0]  header_bytes_q;
	logic        out_valid_q;
	logic        out_ok_q;
	logic [31:0] out_address_q;
	logic [7:0]  out_start_q;
	logic [8:0]  out_pages_q;
	logic        res_ready;
	logic        res_valid;
	res_t        res;
	mem_req_t    mem_req;
	logic [7:0]  rd_data;
	logic [31:0] address_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q    <= 32'd0;
			header_bytes_q <= 8'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEAP_BASE:    heap_base_q    <= cfg_data;
				REG_HEADER_BYTES: header_bytes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bffa_ctrl #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.request_bytes(s_axis_tdata[REQ_W-1:0]),
		.header_bytes (header_bytes_q),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.res          (res),
		.mem_req      (mem_req),
		.rd_data      (rd_data)
	);

	bffa_bitmap_mem #(
		.DEPTH(BITMAP_BYTES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_data(rd_data)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	assign address_d = res.ok
		? heap_base_q + (32'(res.start) << PAGE_SHIFT) + 32'(header_bytes_q)
		: 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_ok_q      <= res.ok;
			out_address_q <= address_d;
			out_start_q   <= res.start[7:0];
			out_pages_q   <= res.pages_taken;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_pages_q, out_start_q, out_address_q, out_ok_q};

`ifndef SYNTHESIS
	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[TDATA_OUT_W-1:1] == '0)
		else $error("failed allocation carries nonzero fields");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
		else $error("bitmap read and write to the same word in one cycle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !mem_req.wr_en)
		else $error("bitmap written while idle");

	a_result_safe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid_q || m_axis_tready)
		else $error("result overwrote a pending transaction");
`endif

endmodule

@@ src/bffa_bitmap_mem.sv @@
`timescale 1ns / 1ps
module bffa_bitmap_mem import bffa_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_q;
	logic             rd_vld_q;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    wa;

	assign ra = req.rd_addr[AW-1:0];
	assign wa = req.wr_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wa] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[ra];
		end
	end

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[wa] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= valid_q[ra];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 8'h00;

endmodule

@@ src/bffa_ctrl.sv @@
`timescale 1ns / 1ps
module bffa_ctrl import bffa_pkg::*; #(
	parameter int BITMAP_BYTES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] request_bytes,
	input  logic [7:0]       header_bytes,
	input  logic             res_ready,
	output logic             res_valid,
	output res_t             res,
	output mem_req_t         mem_req,
	input  logic [7:0]       rd_data
);

	localparam int TOTAL_PAGES = BITMAP_BYTES * 8;
	localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	localparam int PW = $clog2(TOTAL_PAGES + 1);

	state_t              state_q;
	state_t              state_d;
	logic [TOTAL_W-1:0]  total_q;
	logic [PW-1:0]       n_q;
	logic [AW-1:0]       cw_q;
	logic [AW-1:0]       mw_q;
	logic [PW-1:0]       run_q;
	logic [PW-1:0]       start_q;
	logic [PW-1:0]       end_q;
	logic                ok_q;

	logic [NFULL_W-1:0]  n_full;
	logic                n_zero;
	logic                n_big;
	logic [PW-1:0]       run_v;
	logic [PW-1:0]       start_v;
	logic [PW-1:0]       end_v;
	logic                hit;
	logic                last_word;
	logic [AW-1:0]       sw;
	logic [AW-1:0]       ew;
	logic [7:0]          mask;

	// round up to whole pages
	assign n_full = NFULL_W'(total_q >> PAGE_SHIFT) + NFULL_W'(|total_q[PAGE_SHIFT-1:0]);
	assign n_zero = (n_full == '0);
	assign n_big  = (n_full > NFULL_W'(TOTAL_PAGES));

	// walk one bitmap word, most significant bit is the lowest page
	always_comb begin
		logic [PW-1:0] page_v;
		run_v   = run_q;
		start_v = start_q;
		end_v   = end_q;
		hit     = 1'b0;
		page_v  = '0;
		for (int b = 0; b < 8; b++) begin
			if (!hit) begin
				page_v = PW'({cw_q, 3'(b)});
				if (rd_data[7-b]) begin
					start_v = page_v + PW'(1);
					run_v   = '0;
				end else begin
					run_v = run_v + PW'(1);
					if (run_v >= n_q) begin
						hit   = 1'b1;
						end_v = page_v;
					end
				end
			end
		end
	end

	assign last_word = (cw_q == AW'(BITMAP_BYTES - 1));
	assign sw        = AW'(start_v >> 3);
	assign ew        = AW'(end_q >> 3);

	always_comb begin
		logic [PW-1:0] page_m;
		page_m = '0;
		for (int b = 0; b < 8; b++) begin
			page_m      = PW'({mw_q, 3'(b)});
			mask[7-b]   = (page_m >= start_q) && (page_m <= end_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CALC;
			ST_CALC: begin
				if (n_zero || n_big) state_d = ST_RESP;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit) state_d = ST_MARK;
				else if (last_word) state_d = ST_RESP;
			end
			ST_MARK: if (mw_q == ew) state_d = ST_RESP;
			ST_RESP: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_req   = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CALC: begin
				if (!n_zero && !n_big) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = '0;
				end
			end
			ST_SCAN: begin
				// on a hit, fetch the first word of the run for marking
				if (hit) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = WADDR_W'(sw);
				end else if (!last_word) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = WADDR_W'(cw_q) + WADDR_W'(1);
				end
			end
			ST_MARK: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = WADDR_W'(mw_q);
				mem_req.wr_data = rd_data | mask;
				if (mw_q != ew) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = WADDR_W'(mw_q) + WADDR_W'(1);
				end
			end
			ST_RESP: res_valid = res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					total_q <= {1'b0, request_bytes} + TOTAL_W'(header_bytes);
				end
			end
			ST_CALC: begin
				n_q     <= PW'(n_full);
				cw_q    <= '0;
				run_q   <= '0;
				start_q <= '0;
				ok_q    <= n_zero;
			end
			ST_SCAN: begin
				run_q   <= run_v;
				start_q <= start_v;
				cw_q    <= cw_q + AW'(1);
				if (hit) begin
					end_q <= end_v;
					mw_q  <= sw;
					ok_q  <= 1'b1;
				end
			end
			ST_MARK: mw_q <= mw_q + AW'(1);
			ST_RESP: ;
			default: ;
		endcase
	end

	assign res.ok          = ok_q;
	assign res.start       = ok_q ? PAGE_W'(start_q) : '0;
	assign res.pages_taken = ok_q ? 9'(n_q) : 9'd0;

endmodule

@@ tb/tb_bitmap_first_fit_page_allocator_unit.sv @@
`timescale 1ns / 1ps
module tb_bitmap_first_fit_page_allocator_unit;
	import bffa_pkg::*;

	localparam int BITMAP_BYTES    = 32;
	localparam int TOTAL_PAGES     = BITMAP_BYTES * 8;
	localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int PHASES          = 6;
	localparam int SCAN_LATENCY    = 2 * BITMAP_BYTES + 4;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam logic [7:0] REG_SPARE_FIRST = 8'd2;

	typedef struct packed {
		logic        ok;
		logic [31:0] address;
		logic [7:0]  start_page;
		logic [8:0]  pages_taken;
	} grant_t;

	class page_alloc_scoreboard;
		bit          page_used[TOTAL_PAGES];
		logic [31:0] heap_base;
		logic [7:0]  header_bytes;
		grant_t      pending[$];
		int          mismatches;

		function new();
			foreach (page_used[p])
				page_used[p] = 1'b0;
			heap_base    = 32'd0;
			header_bytes = 8'd4;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [31:0] data);
			case (idx)
				REG_HEAP_BASE:    heap_base = data;
				REG_HEADER_BYTES: header_bytes = data[7:0];
				default: ;
			endcase
		endfunction

		function int widest_free_run();
			int run;
			int widest;
			run    = 0;
			widest = 0;
			for (int p = 0; p < TOTAL_PAGES; p++) begin
				run = page_used[p] ? 0 : run + 1;
				if (run > widest)
					widest = run;
			end
			return widest;
		endfunction

		// First fit over the page map; the sum and the rounding are exact.
		function void note_request(logic [31:0] req_bytes);
			logic [32:0]     total;
			longint unsigned need;
			int              start;
			int              run;
			bit              found;
			grant_t          g;
			total = {1'b0, req_bytes} + {25'd0, header_bytes};
			need  = total >> PAGE_SHIFT;
			if (total[PAGE_SHIFT-1:0] != '0)
				need++;
			start = 0;
			run   = 0;
			found = (need == 0);
			if (!found && need <= TOTAL_PAGES) begin
				for (int p = 0; p < TOTAL_PAGES; p++) begin
					if (page_used[p]) begin
						start = p + 1;
						run   = 0;
					end else begin
						run++;
						if (run >= need) begin
							found = 1'b1;
							break;
						end
					end
				end
			end
			g = '0;
			if (found) begin
				for (int p = 0; p < need; p++)
					page_used[start + p] = 1'b1;
				g.ok          = 1'b1;
				g.address     = heap_base + (32'(start) << PAGE_SHIFT) + 32'(header_bytes);
				g.start_page  = 8'(start);
				g.pages_taken = 9'(need);
			end
			pending.push_back(g);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_grant(logic [TDATA_OUT_W-1:0] d);
			grant_t g;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending: expected none, actual %h",
					$time, d);
				return;
			end
			g = pending.pop_front();
			field_check("ok", 32'(g.ok), 32'(d[0]));
			field_check("address", g.address, d[32:1]);
			field_check("start_page", 32'(g.start_page), 32'(d[40:33]));
			field_check("pages_taken", 32'(g.pages_taken), 32'(d[49:41]));
			field_check("padding", 32'd0, 32'(d[55:50]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [7:0]             cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	page_alloc_scoreboard alloc_sb = new();
	bit                   no_idle = 1'b0;
	int                   cycle_count = 0;

	bitmap_first_fit_page_allocator_unit #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL bitmap_first_fit_page_allocator_unit");
			$finish;
		end
	end

	// Result side: random stall per transaction, then check against the oldest grant.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(10, 0);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			alloc_sb.check_grant(m_axis_tdata);
		end
	end

	task automatic send_request(input logic [31:0] req_bytes);
		int gap;
		gap = no_idle ? 0 : $urandom_range(10, 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req_bytes;
		do @(posedge clk); while (!s_axis_tready);
		alloc_sb.note_request(req_bytes);
	endtask

	// Hold off new requests until every pending grant has been checked.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (alloc_sb.pending.size() != 0);
	endtask

	task automatic cfg_write(input logic [7:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		alloc_sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_request();
		int r;
		int hdr;
		int widest;
		r      = $urandom_range(99, 0);
		hdr    = alloc_sb.header_bytes;
		widest = alloc_sb.widest_free_run();
		if (r < 25)
			return $urandom_range(PAGE_BYTES, 0);
		if (r < 35)
			return 32'd0;
		// land on or just past a page boundary
		if (r < 45)
			return $urandom_range(4, 1) * PAGE_BYTES - hdr + $urandom_range(1, 0);
		// one page more than the widest free run
		if (r < 48)
			return (widest + 1) * PAGE_BYTES - hdr;
		if (r == 48)
			return (widest == 0) ? 32'd0 : widest * PAGE_BYTES - hdr;
		if (r < 65)
			return $urandom_range(16 * PAGE_BYTES, 0);
		return $urandom;
	endfunction

	initial begin
		logic [31:0] base;
		logic [7:0]  hdr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: base 0, header 4
		send_request(32'd0);
		send_request(32'd4092);
		send_request(32'd4093);
		send_request(32'hFFFF_FFFF);
		send_request(32'(TOTAL_PAGES * PAGE_BYTES - 4));
		send_request(32'h5555_5555);
		drain();
		cfg_write(REG_HEADER_BYTES, 32'hFFFF_FF00);
		cfg_write(REG_HEAP_BASE, 32'hFFFF_FFFF);
		send_request(32'd0);
		send_request(32'd1);
		send_request(32'(PAGE_BYTES));
		send_request(32'(PAGE_BYTES + 1));
		send_request(32'd0);
		drain();
		cfg_write(REG_SPARE_FIRST, 32'hDEAD_BEEF);
		cfg_write(8'hFF, 32'h0000_0001);
		cfg_write(REG_HEADER_BYTES, 32'd255);
		cfg_write(REG_HEAP_BASE, 32'd0);
		send_request(32'hFFFF_FFFF);
		send_request(32'hFFFF_FF01);
		send_request(32'd0);
		send_request(32'hAAAA_AAAA);
		send_request(32'((alloc_sb.widest_free_run() + 1) * PAGE_BYTES - 255));
		send_request(32'(64 * PAGE_BYTES - 255));
		send_request(32'(64 * PAGE_BYTES - 254));

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin base = 32'hFFFF_FFFF; hdr = 8'd255; end
				1: begin base = 32'd0; hdr = 8'd0; end
				2: begin base = $urandom; hdr = 8'($urandom_range(255, 0)); end
				3: begin base = 32'h8000_0000; hdr = 8'd1; end
				4: begin base = $urandom; hdr = 8'd0; end
				default: begin base = $urandom; hdr = 8'($urandom_range(255, 0)); end
			endcase
			cfg_write(8'($urandom_range(8'hFF, REG_SPARE_FIRST)), $urandom);
			cfg_write(REG_HEAP_BASE, base);
			cfg_write(REG_HEADER_BYTES, {24'($urandom), hdr});
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if (i % 40 == 0)
					no_idle = (phase == 2) || ($urandom_range(3, 0) == 0);
				send_request(pick_request());
			end
		end

		drain();
		repeat (SCAN_LATENCY + 32) @(posedge clk);
		if (alloc_sb.mismatches == 0 && alloc_sb.pending.size() == 0) begin
			$display("PASS bitmap_first_fit_page_allocator_unit");
		end else begin
			$display("FAIL bitmap_first_fit_page_allocator_unit");
		end
		$finish;
	end

endmodule
